/* rtl/ptst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptst_pkg: shared types and constants of the periodic timer slot table
// Holds the table geometry, operation and result codes, and the layout of
// one slot entry in the slot store.
// ----------------------------------------------------------------------------
package ptst_pkg;

    // Table geometry.
    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = 3;
    localparam int USE_W      = $clog2(SLOT_COUNT + 1);
    localparam int PERIOD_W   = 32;

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ATTACH  = 2'd1,
        OP_DETACH  = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    // Result kinds carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_GRANTED = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_EXPIRED = 2'd2
    } kind_t;

    // One slot entry: reload period and current count.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] remaining;
    } slot_entry_t;

    // Write request into the slot store.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_entry_t       data;
    } slot_wr_t;

endpackage
`default_nettype wire

/* rtl/ptst_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptst_store: slot entry memory
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
module ptst_store (
    input  wire                           aclk,
    input  wire ptst_pkg::slot_wr_t       wr,
    input  wire [ptst_pkg::SLOT_W-1:0]    rd_addr,
    output ptst_pkg::slot_entry_t         rd_data
);
    import ptst_pkg::*;

    slot_entry_t mem [SLOT_COUNT];
    slot_entry_t rd_data_reg;

    // Synchronous write and registered read.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/periodic_timer_slot_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_slot_table: table of periodic countdown timer slots
// Eight slots, each with a 32-bit period and count, driven by one request
// per input item.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one request: tuser is the operation (tick, attach,
// detach, restart) and tdata carries the period and the slot index.
// The master channel returns results: tuser is the kind (granted, full,
// expired), tdata the slot index, and tlast marks the last result of a
// request.
// Attach answers with one result on the cycle after acceptance. Detach is
// done on acceptance; restart reads the slot, then writes it back.
// A tick walks the slot memory one slot per cycle through its single read
// port while the output does not hold it, then releases the final expiry
// in a flush step; each expiry leaves as the next one is found.
// A request is accepted only while the block is idle and the output
// register is free or being drained. When the receiver stalls, a tick
// holds on the slot that needs the output until the register frees up.
// Reset clears the enable bits, the occupancy count and the output; the
// period and count memory is not cleared, so the user must load every slot
// by attach before it is used; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module periodic_timer_slot_table (
    input  wire         aclk,
    input  wire         aresetn,
    // Request channel.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [31:0] period, [34:32] slot, [39:35] zero
    input  wire  [1:0]  s_tuser,   // [1:0] op
    // Result channel.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [2:0] slot_index, [7:3] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import ptst_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_TICK    = 4'b0010,
        ST_FLUSH   = 4'b0100,
        ST_RESTART = 4'b1000
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [USE_W-1:0]  FULL_USE  = USE_W'(SLOT_COUNT);

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [SLOT_COUNT-1:0] en_reg, en_next;
    logic [USE_W-1:0]      use_reg, use_next;
    logic                  pend_v_reg, pend_v_next;
    logic [SLOT_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                  m_valid_reg, m_valid_next;
    kind_t                 m_kind_reg, m_kind_next;
    logic [SLOT_W-1:0]     m_idx_reg, m_idx_next;
    logic                  m_last_reg, m_last_next;

    slot_wr_t              wr;
    slot_entry_t           rd_data;

    logic [PERIOD_W-1:0]   in_period;
    logic [SLOT_W-1:0]     in_slot;
    op_t                   in_op;
    logic                  out_free;
    logic                  accept;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [PERIOD_W-1:0]   rem_dec;
    logic                  expire;

    assign in_period = s_tdata[31:0];
    assign in_slot   = s_tdata[34:32];
    assign in_op     = op_t'(s_tuser);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;

    // Lowest free slot for attach.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (!en_reg[k]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(k);
            end
        end
    end

    // Countdown of the slot whose entry is on the read port.
    assign rem_dec = rd_data.remaining - PERIOD_W'(1);
    assign expire  = (rem_dec == '0);

    // Sequencer and read-modify-write control.
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        en_next       = en_reg;
        use_next      = use_reg;
        pend_v_next   = pend_v_reg;
        pend_idx_next = pend_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_idx_next    = m_idx_reg;
        m_last_next   = m_last_reg;
        wr            = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_TICK: begin
                            idx_next   = '0;
                            state_next = ST_TICK;
                        end
                        OP_ATTACH: begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (use_reg < FULL_USE && free_found) begin
                                en_next[free_idx]   = 1'b1;
                                use_next            = use_reg + USE_W'(1);
                                wr.en               = 1'b1;
                                wr.addr             = free_idx;
                                wr.data.period      = in_period;
                                wr.data.remaining   = in_period;
                                m_kind_next         = KIND_GRANTED;
                                m_idx_next          = free_idx;
                            end else begin
                                m_kind_next = KIND_FULL;
                                m_idx_next  = '0;
                            end
                        end
                        OP_DETACH: begin
                            if (USE_W'(in_slot) < FULL_USE && en_reg[in_slot]) begin
                                en_next[in_slot] = 1'b0;
                                if (use_reg != '0) begin
                                    use_next = use_reg - USE_W'(1);
                                end
                            end
                        end
                        OP_RESTART: begin
                            if (USE_W'(in_slot) < FULL_USE) begin
                                idx_next   = in_slot;
                                state_next = ST_RESTART;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_TICK: begin
                // Hold on an expiry that needs the output while it is busy.
                if (!(en_reg[idx_reg] && expire && pend_v_reg && !out_free)) begin
                    if (en_reg[idx_reg]) begin
                        wr.en             = 1'b1;
                        wr.addr           = idx_reg;
                        wr.data.period    = rd_data.period;
                        wr.data.remaining = expire ? rd_data.period : rem_dec;
                        if (expire) begin
                            if (pend_v_reg) begin
                                m_valid_next = 1'b1;
                                m_kind_next  = KIND_EXPIRED;
                                m_idx_next   = pend_idx_reg;
                                m_last_next  = 1'b0;
                            end
                            pend_v_next   = 1'b1;
                            pend_idx_next = idx_reg;
                        end
                    end
                    if (idx_reg == LAST_SLOT) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end

            ST_FLUSH: begin
                // The last expiry found carries the last marker.
                if (!pend_v_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_EXPIRED;
                    m_idx_next   = pend_idx_reg;
                    m_last_next  = 1'b1;
                    pend_v_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            ST_RESTART: begin
                wr.en             = 1'b1;
                wr.addr           = idx_reg;
                wr.data.period    = rd_data.period;
                wr.data.remaining = rd_data.period;
                state_next        = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Slot memory; the read address is the slot to be handled next cycle.
    ptst_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            en_reg      <= '0;
            use_reg     <= '0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            en_reg      <= en_next;
            use_reg     <= use_next;
            pend_v_reg  <= pend_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        m_kind_reg   <= m_kind_next;
        m_idx_reg    <= m_idx_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {5'b0, m_idx_reg};
    assign m_tlast  = m_last_reg;

    // The occupancy count always matches the enable bits.
    a_use_count: assert property (@(posedge aclk) disable iff (!aresetn)
        use_reg == USE_W'($countones(en_reg)))
        else $error("occupancy count does not match enabled slots");

    // No expiry is left pending once the block is idle.
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_v_reg)
        else $error("pending expiry lost at end of tick");

    // An accepted tick starts its walk at the first slot.
    a_tick_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_TICK)
        |=> (state_reg == ST_TICK && idx_reg == '0))
        else $error("tick did not start at slot zero");

    // An attach always produces a final result on the next cycle.
    a_attach_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_ATTACH)
        |=> (m_tvalid && m_tlast && (m_tuser == KIND_GRANTED || m_tuser == KIND_FULL)))
        else $error("attach result missing");

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the periodic timer slot table
// Drives attach, detach, restart and tick requests into the block, keeps its
// own copy of the slot table to predict the grant, full and expiry results,
// and compares every result that leaves the block in order of arrival.
// ----------------------------------------------------------------------------
module tb;
    import ptst_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 200;
    localparam int TAIL_ITEMS   = 40;

    // One predicted result of the table.
    typedef struct {
        kind_t             kind;
        logic [SLOT_W-1:0] slot_index;
        logic              last;
    } timer_result_t;

    // Shadow copy of the slot table and the queue of results it predicts.
    class timer_table_model;
        bit                  enabled [SLOT_COUNT];
        logic [PERIOD_W-1:0] period [SLOT_COUNT];
        logic [PERIOD_W-1:0] remaining [SLOT_COUNT];
        int unsigned         in_use;
        timer_result_t       due_results [$];
        int unsigned         errors;

        function new();
            foreach (enabled[k]) begin
                enabled[k]   = 1'b0;
                period[k]    = '0;
                remaining[k] = '0;
            end
            in_use = 0;
            errors = 0;
        endfunction

        // Apply one accepted request and queue the results it causes.
        function void note_request(op_t op, logic [PERIOD_W-1:0] reload,
                                   logic [SLOT_W-1:0] slot);
            timer_result_t res;
            int            first;
            bit            granted;
            first   = due_results.size();
            granted = 1'b0;
            case (op)
                OP_TICK: begin
                    for (int k = 0; k < SLOT_COUNT; k++) begin
                        if (enabled[k]) begin
                            remaining[k] = remaining[k] - 1;
                            if (remaining[k] == '0) begin
                                remaining[k]   = period[k];
                                res.kind       = KIND_EXPIRED;
                                res.slot_index = SLOT_W'(k);
                                res.last       = 1'b0;
                                due_results.push_back(res);
                            end
                        end
                    end
                    if (due_results.size() > first)
                        due_results[due_results.size() - 1].last = 1'b1;
                end
                OP_ATTACH: begin
                    // The lowest free slot is taken; none free means full.
                    if (in_use < SLOT_COUNT) begin
                        for (int k = 0; k < SLOT_COUNT && !granted; k++) begin
                            if (!enabled[k]) begin
                                enabled[k]     = 1'b1;
                                period[k]      = reload;
                                remaining[k]   = reload;
                                in_use++;
                                res.kind       = KIND_GRANTED;
                                res.slot_index = SLOT_W'(k);
                                granted        = 1'b1;
                            end
                        end
                    end
                    if (!granted) begin
                        res.kind       = KIND_FULL;
                        res.slot_index = '0;
                    end
                    res.last = 1'b1;
                    due_results.push_back(res);
                end
                OP_DETACH: begin
                    // Freeing a slot that is already free changes nothing.
                    if (slot < SLOT_COUNT && enabled[slot]) begin
                        enabled[slot] = 1'b0;
                        if (in_use > 0)
                            in_use--;
                    end
                end
                default: begin
                    if (slot < SLOT_COUNT)
                        remaining[slot] = period[slot];
                end
            endcase
        endfunction

        // Compare one result from the block with the oldest prediction.
        function void check_result(kind_t kind, logic [SLOT_W-1:0] slot_index,
                                   logic last);
            timer_result_t want;
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d slot_index %0d last %0d",
                       kind, slot_index, last);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, kind);
                errors++;
            end
            if (slot_index !== want.slot_index) begin
                $error("slot_index: expected %0d, actual %0d",
                       want.slot_index, slot_index);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;     // [31:0] period, [34:32] slot, [39:35] zero
    logic [1:0]  s_tuser  = '0;     // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [2:0] slot_index, [7:3] zero
    logic [1:0]  m_tuser;           // [1:0] kind
    logic        m_tlast;

    timer_table_model table_model = new();
    bit               tail_phase  = 1'b0;
    int               idle_cycles = 0;
    int               stall_left  = 0;

    periodic_timer_slot_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Monitor both channels at the clock edge where the handshake completes.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            table_model.note_request(op_t'(s_tuser), s_tdata[31:0], s_tdata[34:32]);
        if (aresetn && m_tvalid && m_tready)
            table_model.check_result(kind_t'(m_tuser), m_tdata[2:0], m_tlast);
    end

    // Watchdog on cycles in which neither channel moves a request or result.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver stalls come in random bursts, except in the tail of the run.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(op_t op, logic [PERIOD_W-1:0] reload,
                                logic [SLOT_W-1:0] slot);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, slot, reload};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic sender_gap(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Hold off until every predicted result has come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (table_model.due_results.size() != 0)
            @(posedge aclk);
    endtask

    // Mostly short periods so that slots expire often; now and then a
    // full-width value so that every period bit toggles.
    function automatic logic [PERIOD_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 92)
            return '0;
        else
            return $urandom;
    endfunction

    initial begin
        int   r;
        op_t  op;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: fill the table with extreme and short periods.
        send_request(OP_ATTACH, 32'd1, 3'd0);
        send_request(OP_ATTACH, 32'd0, 3'd7);
        send_request(OP_ATTACH, 32'hFFFF_FFFF, 3'd0);
        send_request(OP_ATTACH, 32'd2, 3'd0);
        send_request(OP_ATTACH, 32'd3, 3'd0);
        send_request(OP_ATTACH, 32'd1, 3'd0);
        send_request(OP_ATTACH, 32'd1, 3'd0);
        send_request(OP_ATTACH, 32'd1, 3'd0);
        // Table full.
        send_request(OP_ATTACH, 32'd5, 3'd0);
        // Two ticks, each with several expiries and with none due on some slots.
        send_request(OP_TICK, 32'hFFFF_FFFF, 3'd7);
        send_request(OP_TICK, 32'd0, 3'd0);
        send_request(OP_RESTART, 32'd0, 3'd4);
        // Detach a slot twice: the second detach finds it already free.
        send_request(OP_DETACH, 32'd0, 3'd1);
        send_request(OP_DETACH, 32'd0, 3'd1);
        send_request(OP_RESTART, 32'd0, 3'd1);
        send_request(OP_DETACH, 32'd0, 3'd2);
        send_request(OP_DETACH, 32'd0, 3'd3);
        send_request(OP_DETACH, 32'd0, 3'd4);
        send_request(OP_ATTACH, 32'd1, 3'd0);
        send_request(OP_ATTACH, 32'd1, 3'd0);
        send_request(OP_ATTACH, 32'd1, 3'd0);
        send_request(OP_ATTACH, 32'd1, 3'd0);
        // Every slot has period one: all eight expire on one tick.
        send_request(OP_TICK, 32'd0, 3'd0);
        send_request(OP_RESTART, 32'd0, 3'd7);
        wait_for_drain();

        // Random part: every slot has been loaded, so any slot may be restarted.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase = 1'b1;
            if (n == RANDOM_ITEMS / 2)
                wait_for_drain();
            else if (!tail_phase && $urandom_range(0, 3) == 0)
                sender_gap($urandom_range(1, 9));
            r = $urandom_range(0, 99);
            if (r < 40)
                op = OP_TICK;
            else if (r < 65)
                op = OP_ATTACH;
            else if (r < 85)
                op = OP_DETACH;
            else
                op = OP_RESTART;
            if (op == OP_ATTACH)
                send_request(op, pick_period(), SLOT_W'($urandom_range(0, 7)));
            else
                send_request(op, $urandom, SLOT_W'($urandom_range(0, 7)));
        end

        // Let the last results come out, then allow the block to settle.
        wait_for_drain();
        repeat (20) @(posedge aclk);
        if (table_model.errors == 0 && table_model.due_results.size() == 0) begin
            $display("tb: success");
        end else begin
            if (table_model.due_results.size() != 0)
                $error("%0d results never arrived", table_model.due_results.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
